// File: src/nsr_pkg.sv
package nsr_pkg;

   // Capacity of the note store
   localparam int MAX_NOTES = 64;
   localparam int ADDR_W    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int CNT_W     = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NOTES);

   // Command codes on the request channel
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_BEGIN = 3'd2;
   localparam logic [2:0] CMD_END   = 3'd3;
   localparam logic [2:0] CMD_PLAY  = 3'd4;

   // Result codes
   localparam logic [2:0] RES_IGNORED   = 3'd0;
   localparam logic [2:0] RES_ACCEPTED  = 3'd1;
   localparam logic [2:0] RES_ZERO      = 3'd2;
   localparam logic [2:0] RES_OVERFLOW  = 3'd3;
   localparam logic [2:0] RES_FULL      = 3'd4;
   localparam logic [2:0] RES_STOP_NONE = 3'd5;
   localparam logic [2:0] RES_STOP_SOME = 3'd6;
   localparam logic [2:0] RES_PLAY      = 3'd7;

   typedef struct packed {
      logic [2:0]         command;
      logic [31:0]        time_ms;
      logic signed [15:0] note_in;
   } nsr_req_type;

   typedef struct packed {
      logic [2:0]         event_res;
      logic signed [15:0] note_out;
      logic [15:0]        duration_ms;
      logic [15:0]        gap_ms;
      logic               is_last;
      logic               recording;
      logic [CNT_W-1:0]   note_count;
      logic               stop_tone;
   } nsr_rsp_type;

   typedef enum logic [2:0] {
      OP_START,
      OP_STOP,
      OP_BEGIN,
      OP_END,
      OP_PLAY,
      OP_NONE
   } nsr_op_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      nsr_op_type         op;
      logic [31:0]        time_ms;
      logic signed [15:0] note;
   } nsr_cmd_type;

endpackage

// File: src/nsr_front.sv
module nsr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nsr_pkg::nsr_req_type req_item,
   output logic                 q_valid,
   output nsr_pkg::nsr_cmd_type q_item,
   input  logic                 q_pop
);

   nsr_pkg::nsr_cmd_type q_ff [nsr_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   nsr_pkg::nsr_cmd_type cls;

   always_comb begin
      cls.time_ms = req_item.time_ms;
      cls.note    = req_item.note_in;
      unique case (req_item.command)
         nsr_pkg::CMD_START: cls.op = nsr_pkg::OP_START;
         nsr_pkg::CMD_STOP:  cls.op = nsr_pkg::OP_STOP;
         nsr_pkg::CMD_BEGIN: cls.op = nsr_pkg::OP_BEGIN;
         nsr_pkg::CMD_END:   cls.op = nsr_pkg::OP_END;
         nsr_pkg::CMD_PLAY:  cls.op = nsr_pkg::OP_PLAY;
         default:            cls.op = nsr_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'(nsr_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: src/nsr_back.sv
module nsr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  nsr_pkg::nsr_cmd_type q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nsr_pkg::nsr_rsp_type rsp_item
);

   localparam int AW = nsr_pkg::ADDR_W;
   localparam int CW = nsr_pkg::CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_END_FIN,
      ST_PLAY_RD,
      ST_PLAY_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic                 rec_ff, rec_in;
   logic [31:0]          start_ff, start_in;
   logic [31:0]          nso_ff, nso_in;
   logic [31:0]          prev_ff, prev_in;
   logic [31:0]          end_off_ff, end_off_in;
   logic [15:0]          pend_ff, pend_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   nsr_pkg::nsr_rsp_type rsp_ff, rsp_in;

   logic [15:0] note_mem [nsr_pkg::MAX_NOTES];
   logic [15:0] dur_mem  [nsr_pkg::MAX_NOTES];
   logic [15:0] gap_mem  [nsr_pkg::MAX_NOTES];
   logic [15:0] note_rd_ff, dur_rd_ff, gap_rd_ff;

   logic          out_free, load;
   logic [2:0]    res;
   logic          tone;
   logic [31:0]   dur, gap;
   logic [CW-1:0] cnt_inc;
   logic          last;
   logic          wr_entry, wr_gap;
   logic [AW-1:0] wr_idx, gap_idx;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign dur      = end_off_ff - nso_ff;
   assign gap      = nso_ff - prev_ff;
   assign cnt_inc  = cnt_ff + CW'(1);
   assign last     = ({1'b0, idx_ff} + CW'(1)) == cnt_ff;
   assign wr_idx   = cnt_ff[AW-1:0];
   assign gap_idx  = wr_idx - AW'(1);

   always_comb begin
      state_in   = state_ff;
      rec_in     = rec_ff;
      start_in   = start_ff;
      nso_in     = nso_ff;
      prev_in    = prev_ff;
      end_off_in = end_off_ff;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;
      load       = 1'b0;
      res        = nsr_pkg::RES_IGNORED;
      tone       = 1'b0;
      wr_entry   = 1'b0;
      wr_gap     = 1'b0;
      rsp_in     = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               load  = 1'b1;
               unique case (q_item.op)
                  nsr_pkg::OP_START: begin
                     if (!rec_ff) begin
                        cnt_in   = '0;
                        rec_in   = 1'b1;
                        start_in = q_item.time_ms;
                        res      = nsr_pkg::RES_ACCEPTED;
                     end
                  end
                  nsr_pkg::OP_STOP: begin
                     if (rec_ff) begin
                        rec_in = 1'b0;
                        res    = (cnt_ff == '0) ? nsr_pkg::RES_STOP_NONE
                                                : nsr_pkg::RES_STOP_SOME;
                     end
                  end
                  nsr_pkg::OP_BEGIN: begin
                     if (rec_ff) begin
                        nso_in  = q_item.time_ms - start_ff;
                        pend_in = q_item.note;
                        res     = nsr_pkg::RES_ACCEPTED;
                     end
                  end
                  nsr_pkg::OP_END: begin
                     if (rec_ff) begin
                        end_off_in = q_item.time_ms - start_ff;
                        load       = 1'b0;
                        state_in   = ST_END_FIN;
                     end
                  end
                  nsr_pkg::OP_PLAY: begin
                     if (!rec_ff && cnt_ff != '0 && cnt_ff <= nsr_pkg::MAX_CNT) begin
                        idx_in   = '0;
                        load     = 1'b0;
                        state_in = ST_PLAY_RD;
                     end
                  end
                  nsr_pkg::OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_END_FIN: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (dur == 32'd0) begin
                  res = nsr_pkg::RES_ZERO;
               end else if (dur[31:16] != 16'd0 || cnt_ff >= nsr_pkg::MAX_CNT) begin
                  rec_in = 1'b0;
                  res    = nsr_pkg::RES_OVERFLOW;
               end else if (cnt_ff != '0 && gap[31:16] != 16'd0) begin
                  rec_in = 1'b0;
                  res    = nsr_pkg::RES_OVERFLOW;
               end else begin
                  wr_entry = 1'b1;
                  wr_gap   = (cnt_ff != '0);
                  prev_in  = end_off_ff;
                  cnt_in   = cnt_inc;
                  if (cnt_inc >= nsr_pkg::MAX_CNT) begin
                     rec_in = 1'b0;
                     tone   = 1'b1;
                     res    = nsr_pkg::RES_FULL;
                  end else begin
                     res = nsr_pkg::RES_ACCEPTED;
                  end
               end
            end
         end
         ST_PLAY_RD: begin
            state_in = ST_PLAY_EMIT;
         end
         ST_PLAY_EMIT: begin
            if (out_free) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_PLAY_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_in.event_res   = res;
         rsp_in.note_out    = '0;
         rsp_in.duration_ms = '0;
         rsp_in.gap_ms      = '0;
         rsp_in.is_last     = 1'b0;
         rsp_in.recording   = rec_in;
         rsp_in.note_count  = cnt_in;
         rsp_in.stop_tone   = tone;
      end else if (state_ff == ST_PLAY_EMIT && out_free) begin
         rsp_in.event_res   = nsr_pkg::RES_PLAY;
         rsp_in.note_out    = note_rd_ff;
         rsp_in.duration_ms = dur_rd_ff;
         rsp_in.gap_ms      = last ? 16'd0 : gap_rd_ff;
         rsp_in.is_last     = last;
         rsp_in.recording   = rec_ff;
         rsp_in.note_count  = cnt_ff;
         rsp_in.stop_tone   = 1'b0;
      end

      if (load || (state_ff == ST_PLAY_EMIT && out_free)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rec_ff       <= 1'b0;
         start_ff     <= '0;
         nso_ff       <= '0;
         prev_ff      <= '0;
         end_off_ff   <= '0;
         pend_ff      <= '1;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rec_ff       <= rec_in;
         start_ff     <= start_in;
         nso_ff       <= nso_in;
         prev_ff      <= prev_in;
         end_off_ff   <= end_off_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // Entry store: note and duration share a write address, gap trails by one
   always_ff @(posedge clock) begin
      if (wr_entry) begin
         note_mem[wr_idx] <= pend_ff;
         dur_mem[wr_idx]  <= dur[15:0];
      end
      if (wr_gap) begin
         gap_mem[gap_idx] <= gap[15:0];
      end
      note_rd_ff <= note_mem[idx_ff];
      dur_rd_ff  <= dur_mem[idx_ff];
      gap_rd_ff  <= gap_mem[idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: src/note_sequence_recorder.sv
// Note sequence recorder. Commands (start, stop, note begin, note end, play)
// arrive as items with a millisecond timestamp and enter a two-item queue,
// so the request side keeps flowing until the queue is full while the back
// end is busy or the result side stalls. Each command gives one result
// item, except play, which gives one item per stored entry (is_last on the
// final one). In the back end, start, stop, note begin and ignored commands
// finish in the idle state; note end does the offset subtract, then the
// duration/gap check and store write; play takes the command, then per entry
// does a registered read of the entry store and an emit that waits on result
// stalls. Up to 64 entries are held; unwritten entries are never read by play.
module note_sequence_recorder (
   input  logic                 clock,
   input  logic                 reset,
   // request items
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nsr_pkg::nsr_req_type req_item,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nsr_pkg::nsr_rsp_type rsp_item
);

   logic                 q_valid;
   logic                 q_pop;
   nsr_pkg::nsr_cmd_type q_item;

   // front: accept and decode, queue items
   nsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // back: recorder state, entry store, play walk and result register
   nsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
